// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset
`define SRTC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define SRTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/srtc_pkg.sv -----
// ----------------------------------------------------------------------------
// srtc_pkg
// Shared types and constants of the SPI real-time clock register interface.
// ----------------------------------------------------------------------------
package srtc_pkg;

  // Default sizes of the register file and user RAM
  localparam int CLOCK_REG_COUNT_DEF = 18;
  localparam int USER_BYTES_DEF      = 96;

  // Address map
  localparam logic [7:0] ADDR_USER_BASE  = 8'h20;
  localparam logic [7:0] ADDR_WRITE_BIT  = 8'h80;
  localparam logic [7:0] ADDR_WR_USER    = 8'hA0;
  localparam logic [6:0] AREA_WRAP_CLOCK = 7'h20;
  localparam logic [6:0] AREA_WRAP_USER  = 7'h00;
  localparam logic [7:0] CLOCK_AREA_SPAN = 8'h20;
  localparam logic [7:0] USER_AREA_SPAN  = 8'h60;

  // Hour register flags
  localparam logic [7:0] HOUR_MODE_12 = 8'h40;
  localparam logic [7:0] HOUR_PM      = 8'h20;

  // Bit counter: address bits 0-7, data bits 8-15
  localparam logic [3:0] PHASE_DATA_FIRST = 4'd8;
  localparam logic [3:0] PHASE_DATA_LAST  = 4'd15;

  // Writable bits of each clock register
  localparam logic [7:0] WRITE_MASK [32] = '{
    8'h7F, 8'h7F, 8'h7F, 8'h0F, 8'h3F, 8'h3F, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h8F, 8'h87,
    8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
  };

  // Time snapshot in register format
  typedef struct packed {
    logic [7:0] seconds;
    logic [7:0] minutes;
    logic [7:0] hours;
    logic [7:0] weekday;
    logic [7:0] day_of_month;
    logic [7:0] month;
    logic [7:0] year;
  } srtc_time_t;

endpackage

// ----- rtl/core/srtc_ram.sv -----
// ----------------------------------------------------------------------------
// srtc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = srtc_pkg::USER_BYTES_DEF
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; rdata holds between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/srtc_time_bcd.sv -----
// ----------------------------------------------------------------------------
// srtc_time_bcd
// Converts the binary time snapshot into clock register (BCD) format.
// ----------------------------------------------------------------------------
module srtc_time_bcd (
  input  logic [5:0]              now_seconds,
  input  logic [5:0]              now_minutes,
  input  logic [4:0]              now_hours,
  input  logic [2:0]              now_weekday,
  input  logic [4:0]              now_day_of_month,
  input  logic [3:0]              now_month,
  input  logic [6:0]              now_year,
  input  logic                    mode_12h,
  output srtc_pkg::srtc_time_t    time_regs
);

  // Tens via reciprocal multiply (exact for every 7-bit input)
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  rem;
    prod = {8'd0, v} * 15'd205;
    tens = prod[14:11];
    rem  = v - 7'({3'd0, tens} * 7'd10);
    return {tens, 4'd0} + {4'd0, rem[3:0]};
  endfunction

  logic       pm;
  logic [4:0] hr_sub;
  logic [4:0] hr_12;

  // 12-hour conversion: 0 shows as 12, afternoon flag in bit 5
  always_comb begin
    pm     = (now_hours >= 5'd12);
    hr_sub = pm ? (now_hours - 5'd12) : now_hours;
    hr_12  = (hr_sub == 5'd0) ? 5'd12 : hr_sub;
  end

  always_comb begin
    time_regs.seconds      = to_bcd({1'b0, now_seconds});
    time_regs.minutes      = to_bcd({1'b0, now_minutes});
    if (mode_12h) begin
      time_regs.hours = to_bcd({2'd0, hr_12}) | (pm ? srtc_pkg::HOUR_PM : 8'h00)
                        | srtc_pkg::HOUR_MODE_12;
    end else begin
      time_regs.hours = to_bcd({2'd0, now_hours});
    end
    time_regs.weekday      = {5'd0, now_weekday} + 8'd1;
    time_regs.day_of_month = to_bcd({2'd0, now_day_of_month});
    time_regs.month        = to_bcd({3'd0, now_month} + 7'd1);
    time_regs.year         = to_bcd(now_year);
  end

endmodule

// ----- rtl/core/spi_rtc_register_interface.sv -----
// ----------------------------------------------------------------------------
// spi_rtc_register_interface
// SPI slave register interface of a real-time clock, one pin sample per beat.
//
//  channel | ports                                   | dir | handshake
//  --------+-----------------------------------------+-----+---------------
//  input   | in_chip_select .. in_now_year           | in  | in_valid/in_stall
//  result  | out_serial_data_out                     | out | out_valid/out_stall
//
//  A beat is captured in an input register, processed, and its MISO level
//  lands in the output register: one beat per cycle while the result side
//  does not stall. Reset clears all clock registers and user RAM (per-entry
//  valid bits). A stalled result holds the input register; a new beat is
//  taken as soon as the output register can move.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spi_rtc_register_interface #(
  parameter int CLOCK_REG_COUNT = srtc_pkg::CLOCK_REG_COUNT_DEF,
  parameter int USER_BYTES      = srtc_pkg::USER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_chip_select,
  input  logic       in_serial_clock,
  input  logic       in_serial_data_in,
  input  logic [5:0] in_now_seconds,
  input  logic [5:0] in_now_minutes,
  input  logic [4:0] in_now_hours,
  input  logic [2:0] in_now_weekday,
  input  logic [4:0] in_now_day_of_month,
  input  logic [3:0] in_now_month,
  input  logic [6:0] in_now_year,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_serial_data_out
);

  localparam int         CR_W = $clog2(CLOCK_REG_COUNT);
  localparam int         UA_W = (USER_BYTES > 1) ? $clog2(USER_BYTES) : 1;
  localparam logic [5:0] CR6  = 6'(CLOCK_REG_COUNT);
  localparam logic [7:0] UB8  = 8'(USER_BYTES);

  // Input register
  logic       s1_valid_r;
  logic       cs_r, sck_r, sdi_r;
  logic [5:0] sec_r, min_r;
  logic [4:0] hr_r;
  logic [2:0] wday_r;
  logic [4:0] mday_r;
  logic [3:0] mon_r;
  logic [6:0] year_r;

  // Interface state
  logic [3:0] bit_phase_r, bit_phase_nxt;
  logic [7:0] reg_addr_r, reg_addr_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       out_bit_r, out_bit_nxt;
  logic       sel_r, last_clk_r, last_clk_nxt, idle_clk_r, idle_clk_nxt;
  logic       pend_r, pend_nxt;
  logic       rdv_r, rdv_nxt;
  logic [7:0] clk_regs_r [CLOCK_REG_COUNT];
  logic [7:0] clk_regs_nxt [CLOCK_REG_COUNT];
  logic [7:0] clk_view [CLOCK_REG_COUNT];
  logic       user_vld_r [USER_BYTES];
  logic       out_valid_r;

  logic       in_accept, advance;
  logic [7:0] shift_eff, sh_a;
  logic [3:0] phase_a;
  logic       do_read, do_load, do_write;
  logic [7:0] rd_addr, wr_addr;

  logic       ram_re, ram_we;
  logic [UA_W-1:0] ram_raddr, ram_waddr;
  logic [7:0] ram_rdata;
  logic [6:0] rd_ui, wr_ui;
  logic [4:0] rd_ci, wr_ci;
  logic [7:0] rd_data;
  logic       rd_from_ram;

  srtc_pkg::srtc_time_t time_regs;

  // Handshake: input register moves whenever the output register can
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  function automatic logic [7:0] next_addr(input logic [7:0] a);
    logic [7:0] n;
    n = a + 8'd1;
    if (n[6:0] == srtc_pkg::AREA_WRAP_CLOCK) begin
      n = n - srtc_pkg::CLOCK_AREA_SPAN;
    end else if (n[6:0] == srtc_pkg::AREA_WRAP_USER) begin
      n = n - srtc_pkg::USER_AREA_SPAN;
    end
    return n;
  endfunction

  srtc_time_bcd u_time (
    .now_seconds      (sec_r),
    .now_minutes      (min_r),
    .now_hours        (hr_r),
    .now_weekday      (wday_r),
    .now_day_of_month (mday_r),
    .now_month        (mon_r),
    .now_year         (year_r),
    .mode_12h         (clk_regs_r[2][6]),
    .time_regs        (time_regs)
  );

  // Shift value, taking a pending RAM read into account
  assign shift_eff = pend_r ? (rdv_r ? ram_rdata : 8'h00) : shift_r;

  // Pin sequencing: select tracking, clock edges, bit counter
  always_comb begin
    logic [7:0] addr_in;
    addr_in       = {reg_addr_r[6:0], sdi_r};
    bit_phase_nxt = bit_phase_r;
    reg_addr_nxt  = reg_addr_r;
    out_bit_nxt   = out_bit_r;
    last_clk_nxt  = last_clk_r;
    idle_clk_nxt  = idle_clk_r;
    sh_a          = shift_eff;
    do_read       = 1'b0;
    do_load       = 1'b0;
    do_write      = 1'b0;
    rd_addr       = reg_addr_r;
    wr_addr       = reg_addr_r;
    phase_a       = bit_phase_r;

    if (sel_r != cs_r) begin
      if (!cs_r) begin
        phase_a     = 4'd0;
        out_bit_nxt = 1'b1;
      end else begin
        last_clk_nxt = sck_r;
        idle_clk_nxt = sck_r;
      end
    end
    bit_phase_nxt = phase_a;

    if (cs_r && (last_clk_nxt != sck_r)) begin
      last_clk_nxt = sck_r;
      if (sck_r != idle_clk_nxt) begin
        // Leading edge: shift a read bit out
        if (phase_a[3] && !reg_addr_r[7]) begin
          out_bit_nxt   = shift_eff[7];
          sh_a          = {shift_eff[6:0], 1'b0};
          bit_phase_nxt = phase_a + 4'd1;
          if (phase_a == srtc_pkg::PHASE_DATA_LAST) begin
            bit_phase_nxt = srtc_pkg::PHASE_DATA_FIRST;
            do_read       = 1'b1;
            reg_addr_nxt  = next_addr(reg_addr_r);
          end
        end
      end else if (!phase_a[3]) begin
        // Trailing edge in address phase
        reg_addr_nxt  = addr_in;
        bit_phase_nxt = phase_a + 4'd1;
        if ((phase_a == 4'd7) && !addr_in[7]) begin
          do_load      = (addr_in < srtc_pkg::ADDR_USER_BASE);
          do_read      = 1'b1;
          rd_addr      = addr_in;
          reg_addr_nxt = next_addr(addr_in);
        end
      end else if (reg_addr_r[7]) begin
        // Trailing edge in write data phase
        sh_a          = {shift_eff[6:0], sdi_r};
        bit_phase_nxt = phase_a + 4'd1;
        if (phase_a == srtc_pkg::PHASE_DATA_LAST) begin
          bit_phase_nxt = srtc_pkg::PHASE_DATA_FIRST;
          do_write      = 1'b1;
          reg_addr_nxt  = next_addr(reg_addr_r);
        end
      end
    end
  end

  // Clock registers as seen after a time load
  always_comb begin
    for (int i = 0; i < CLOCK_REG_COUNT; i++) begin
      clk_view[i] = clk_regs_r[i];
    end
    if (do_load) begin
      clk_view[0] = time_regs.seconds;
      clk_view[1] = time_regs.minutes;
      clk_view[2] = time_regs.hours;
      clk_view[3] = time_regs.weekday;
      clk_view[4] = time_regs.day_of_month;
      clk_view[5] = time_regs.month;
      clk_view[6] = time_regs.year;
    end
  end

  // Register read decode
  always_comb begin
    rd_ci       = rd_addr[4:0];
    rd_ui       = 7'(rd_addr - srtc_pkg::ADDR_USER_BASE);
    rd_data     = 8'h00;
    rd_from_ram = 1'b0;
    if (rd_addr < srtc_pkg::ADDR_USER_BASE) begin
      if ({1'b0, rd_ci} < CR6) begin
        rd_data = clk_view[rd_ci[CR_W-1:0]];
      end
    end else if (!rd_addr[7]) begin
      rd_from_ram = ({1'b0, rd_ui} < UB8);
    end else begin
      rd_data = 8'hFF;
    end
  end

  assign ram_re    = advance && do_read && rd_from_ram;
  assign ram_raddr = rd_ui[UA_W-1:0];

  // Write decode: masked clock registers, plain user RAM
  always_comb begin
    wr_ci = wr_addr[4:0];
    wr_ui = 7'(wr_addr - srtc_pkg::ADDR_WR_USER);
    for (int i = 0; i < CLOCK_REG_COUNT; i++) begin
      clk_regs_nxt[i] = clk_view[i];
    end
    ram_we = 1'b0;
    if (do_write && (wr_addr < srtc_pkg::ADDR_WR_USER)) begin
      if ({1'b0, wr_ci} < CR6) begin
        clk_regs_nxt[wr_ci[CR_W-1:0]] = sh_a & srtc_pkg::WRITE_MASK[wr_ci];
      end
    end else if (do_write) begin
      ram_we = advance && ({1'b0, wr_ui} < UB8);
    end
  end

  assign ram_waddr = wr_ui[UA_W-1:0];

  // Shift register source and pending RAM read
  always_comb begin
    shift_nxt = sh_a;
    pend_nxt  = 1'b0;
    rdv_nxt   = rdv_r;
    if (do_read) begin
      shift_nxt = rd_data;
      if (rd_from_ram) begin
        pend_nxt = 1'b1;
        rdv_nxt  = user_vld_r[ram_raddr];
      end
    end
  end

  srtc_ram #(
    .WIDTH (8),
    .DEPTH (USER_BYTES)
  ) u_user_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (sh_a),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cs_r   <= in_chip_select;
      sck_r  <= in_serial_clock;
      sdi_r  <= in_serial_data_in;
      sec_r  <= in_now_seconds;
      min_r  <= in_now_minutes;
      hr_r   <= in_now_hours;
      wday_r <= in_now_weekday;
      mday_r <= in_now_day_of_month;
      mon_r  <= in_now_month;
      year_r <= in_now_year;
    end
  end

  // Control state and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      bit_phase_r <= 4'd0;
      reg_addr_r  <= 8'd0;
      shift_r     <= 8'd0;
      out_bit_r   <= 1'b1;
      sel_r       <= 1'b0;
      last_clk_r  <= 1'b0;
      idle_clk_r  <= 1'b0;
      pend_r      <= 1'b0;
      rdv_r       <= 1'b0;
      out_serial_data_out <= 1'b1;
      for (int i = 0; i < CLOCK_REG_COUNT; i++) begin
        clk_regs_r[i] <= 8'd0;
      end
      for (int i = 0; i < USER_BYTES; i++) begin
        user_vld_r[i] <= 1'b0;
      end
    end else begin
      s1_valid_r  <= in_accept || (s1_valid_r && !advance);
      out_valid_r <= advance || (out_valid_r && out_stall);
      if (advance) begin
        bit_phase_r <= bit_phase_nxt;
        reg_addr_r  <= reg_addr_nxt;
        shift_r     <= shift_nxt;
        out_bit_r   <= out_bit_nxt;
        sel_r       <= cs_r;
        last_clk_r  <= last_clk_nxt;
        idle_clk_r  <= idle_clk_nxt;
        pend_r      <= pend_nxt;
        rdv_r       <= rdv_nxt;
        out_serial_data_out <= out_bit_nxt;
        for (int i = 0; i < CLOCK_REG_COUNT; i++) begin
          clk_regs_r[i] <= clk_regs_nxt[i];
        end
        if (ram_we) begin
          user_vld_r[ram_waddr] <= 1'b1;
        end
      end
    end
  end

  // Checks
  `SRTC_ASSERT(a_desel_idle, clk, rst_n, sel_r || (bit_phase_r == 4'd0 && out_bit_r), "deselected with live bit counter or MISO low")
  `SRTC_ASSERT(a_pend_read, clk, rst_n, !pend_r || !reg_addr_r[7], "pending RAM read in write mode")
  `SRTC_ASSERT_NEXT(a_adv_out, clk, rst_n, advance, out_valid_r, "processed beat lost its result")

endmodule

// ----- verif/spi_rtc_register_interface_checker.sv -----
// ----------------------------------------------------------------------------
// spi_rtc_register_interface_checker
// Watches both channels of the SPI RTC register interface. Every accepted pin
// beat is run through a cycle-free model of the slave (select tracking, bit
// shifting, register file, user RAM, time load) and the predicted MISO level
// is queued. Every accepted result beat is compared with the oldest entry.
// ----------------------------------------------------------------------------
module spi_rtc_register_interface_checker #(
  parameter int CLK_REGS   = 18,
  parameter int USER_BYTES = 96
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_chip_select,
  input  logic       in_serial_clock,
  input  logic       in_serial_data_in,
  input  logic [5:0] in_now_seconds,
  input  logic [5:0] in_now_minutes,
  input  logic [4:0] in_now_hours,
  input  logic [2:0] in_now_weekday,
  input  logic [4:0] in_now_day_of_month,
  input  logic [3:0] in_now_month,
  input  logic [6:0] in_now_year,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_serial_data_out,
  output int         fail_count,
  output int         pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Address map and flags
  localparam logic [7:0] USER_BASE       = 8'h20;
  localparam logic [7:0] WRITE_FLAG      = 8'h80;
  localparam logic [7:0] WRITE_USER_BASE = 8'hA0;
  localparam logic [6:0] CLOCK_WRAP      = 7'h20;
  localparam logic [6:0] USER_WRAP       = 7'h00;
  localparam logic [7:0] CLOCK_SPAN      = 8'h20;
  localparam logic [7:0] USER_SPAN       = 8'h60;
  localparam logic [7:0] HOUR_12H        = 8'h40;
  localparam logic [7:0] HOUR_PM         = 8'h20;
  localparam logic [4:0] PHASE_DATA      = 5'd8;
  localparam logic [4:0] PHASE_END       = 5'd16;

  // Writable bits per clock register; anything past 17 is fully writable
  localparam logic [7:0] CLOCK_WR_MASK [32] = '{
    8'h7F, 8'h7F, 8'h7F, 8'h0F, 8'h3F, 8'h3F, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h8F, 8'h87,
    8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
  };

  // Model state
  logic [7:0] rtc_regs [32];
  logic [7:0] user_ram [96];
  logic [4:0] bit_cnt;
  logic [7:0] addr_reg;
  logic [7:0] shreg;
  logic       miso;
  logic       sel;
  logic       sck_last;
  logic       sck_idle;

  bit miso_expected [$];
  int err_total;

  function automatic logic [7:0] to_packed_bcd(input int unsigned v);
    return 8'(((v / 10) << 4) + (v % 10));
  endfunction

  // Load the shift register from the current address; holes read zero
  task automatic fetch_byte();
    logic [7:0] idx;
    shreg = 8'h00;
    if (addr_reg < USER_BASE) begin
      if (addr_reg < CLK_REGS) shreg = rtc_regs[addr_reg[4:0]];
    end else if (addr_reg < WRITE_FLAG) begin
      idx = addr_reg - USER_BASE;
      if (idx < USER_BYTES) shreg = user_ram[idx];
    end else begin
      shreg = 8'hFF;
    end
  endtask

  // Auto-increment, wrapping inside the clock or user area
  task automatic advance_address();
    addr_reg = addr_reg + 8'd1;
    if (addr_reg[6:0] == CLOCK_WRAP) addr_reg = addr_reg - CLOCK_SPAN;
    else if (addr_reg[6:0] == USER_WRAP) addr_reg = addr_reg - USER_SPAN;
  endtask

  // One pin beat through the slave; leaves the new MISO level in miso
  task automatic step_model();
    logic       cs;
    logic       sck;
    logic       mosi;
    logic [7:0] idx;
    logic [7:0] pm;
    int unsigned hr;
    cs   = in_chip_select;
    sck  = in_serial_clock;
    mosi = in_serial_data_in;

    // select / deselect
    if (sel != cs) begin
      sel = cs;
      if (!cs) begin
        bit_cnt = '0;
        miso    = 1'b1;
      end else begin
        sck_last = sck;
        sck_idle = sck;
      end
    end

    if (cs && sck_last != sck) begin
      sck_last = sck;
      if (sck != sck_idle) begin
        // edge away from idle: shift a read bit out
        if (bit_cnt >= PHASE_DATA && addr_reg < WRITE_FLAG) begin
          miso    = shreg[7];
          shreg   = shreg << 1;
          bit_cnt = bit_cnt + 5'd1;
          if (bit_cnt >= PHASE_END) begin
            bit_cnt = PHASE_DATA;
            fetch_byte();
            advance_address();
          end
        end
      end else if (bit_cnt < PHASE_DATA) begin
        // address bit in
        addr_reg = {addr_reg[6:0], mosi};
        bit_cnt  = bit_cnt + 5'd1;
        if (bit_cnt == PHASE_DATA && addr_reg < WRITE_FLAG) begin
          if (addr_reg < USER_BASE) begin
            // time snapshot into the clock registers, register seven untouched
            rtc_regs[0] = to_packed_bcd(in_now_seconds);
            rtc_regs[1] = to_packed_bcd(in_now_minutes);
            hr = in_now_hours;
            if ((rtc_regs[2] & HOUR_12H) != 8'h00) begin
              pm = 8'h00;
              if (hr >= 12) begin
                pm = HOUR_PM;
                hr = hr - 12;
              end
              if (hr == 0) hr = 12;
              rtc_regs[2] = to_packed_bcd(hr) | pm | HOUR_12H;
            end else begin
              rtc_regs[2] = to_packed_bcd(hr);
            end
            rtc_regs[3] = 8'(in_now_weekday) + 8'd1;
            rtc_regs[4] = to_packed_bcd(in_now_day_of_month);
            rtc_regs[5] = to_packed_bcd(int'(in_now_month) + 1);
            rtc_regs[6] = to_packed_bcd(in_now_year);
          end
          fetch_byte();
          advance_address();
        end
      end else if (addr_reg >= WRITE_FLAG) begin
        // write data bit in
        shreg   = {shreg[6:0], mosi};
        bit_cnt = bit_cnt + 5'd1;
        if (bit_cnt >= PHASE_END) begin
          bit_cnt = PHASE_DATA;
          if (addr_reg < WRITE_USER_BASE) begin
            idx = addr_reg - WRITE_FLAG;
            if (idx < CLK_REGS) rtc_regs[idx[4:0]] = shreg & CLOCK_WR_MASK[idx[4:0]];
          end else begin
            idx = addr_reg - WRITE_USER_BASE;
            if (idx < USER_BYTES) user_ram[idx] = shreg;
          end
          advance_address();
        end
      end
    end
  endtask

  // Predict on input beats, compare on result beats
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (rtc_regs[i]) rtc_regs[i] = 8'h00;
      foreach (user_ram[i]) user_ram[i] = 8'h00;
      bit_cnt  = '0;
      addr_reg = 8'h00;
      shreg    = 8'h00;
      miso     = 1'b1;
      sel      = 1'b0;
      sck_last = 1'b0;
      sck_idle = 1'b0;
      miso_expected.delete();
    end else begin
      if (in_valid && !in_stall) begin
        step_model();
        miso_expected.push_back(miso);
      end
      if (out_valid && !out_stall) begin
        if (miso_expected.size() == 0) begin
          $error("serial_data_out: result beat with nothing expected, actual %0b",
                 out_serial_data_out);
          err_total++;
        end else if (out_serial_data_out !== miso_expected[0]) begin
          $error("serial_data_out mismatch: expected %0b, actual %0b",
                 miso_expected[0], out_serial_data_out);
          err_total++;
          void'(miso_expected.pop_front());
        end else begin
          void'(miso_expected.pop_front());
        end
      end
    end
    fail_count    <= err_total;
    pending_count <= miso_expected.size();
  end

endmodule

// ----- verif/spi_rtc_register_interface_tb.sv -----
// ----------------------------------------------------------------------------
// spi_rtc_register_interface_tb
// Drives SPI pin beats into the RTC register interface: a directed set of
// frames (hour modes, masks, holes, wraps, register seven, aborted frames),
// then random read/write frames in both clock polarities mixed with noise.
// Both channels idle at random; the result side also holds off for long
// stretches to back the block up. The checker beside the block does the rest.
// ----------------------------------------------------------------------------
module spi_rtc_register_interface_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_CLOCK_REGS   = srtc_pkg::CLOCK_REG_COUNT_DEF;
  localparam int N_USER_BYTES   = srtc_pkg::USER_BYTES_DEF;
  localparam int TARGET_BEATS   = 1600;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int NO_CUT         = -1;

  // Address codes used by the directed frames
  localparam logic [7:0] RD_SECONDS  = 8'h00;
  localparam logic [7:0] RD_HOURS    = 8'h02;
  localparam logic [7:0] RD_DATE     = 8'h05;
  localparam logic [7:0] RD_CTRL     = 8'h0E;
  localparam logic [7:0] RD_CLK_TOP  = 8'h1F;
  localparam logic [7:0] RD_USER     = 8'h20;
  localparam logic [7:0] RD_USER_TOP = 8'h7F;
  localparam logic [7:0] WR_CLOCK    = 8'h80;
  localparam logic [7:0] WR_HOURS    = 8'h82;
  localparam logic [7:0] WR_REG7     = 8'h87;
  localparam logic [7:0] WR_CTRL     = 8'h8E;
  localparam logic [7:0] WR_CLK_TOP  = 8'h9F;
  localparam logic [7:0] WR_USER     = 8'hA0;
  localparam logic [7:0] WR_USER_TOP = 8'hFF;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_chip_select;
  logic       in_serial_clock;
  logic       in_serial_data_in;
  logic [5:0] in_now_seconds;
  logic [5:0] in_now_minutes;
  logic [4:0] in_now_hours;
  logic [2:0] in_now_weekday;
  logic [4:0] in_now_day_of_month;
  logic [3:0] in_now_month;
  logic [6:0] in_now_year;
  logic       out_valid;
  logic       out_stall;
  logic       out_serial_data_out;
  int         fail_count;
  int         pending_count;

  always #5 clk = ~clk;

  spi_rtc_register_interface #(
    .CLOCK_REG_COUNT(N_CLOCK_REGS),
    .USER_BYTES     (N_USER_BYTES)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_chip_select     (in_chip_select),
    .in_serial_clock    (in_serial_clock),
    .in_serial_data_in  (in_serial_data_in),
    .in_now_seconds     (in_now_seconds),
    .in_now_minutes     (in_now_minutes),
    .in_now_hours       (in_now_hours),
    .in_now_weekday     (in_now_weekday),
    .in_now_day_of_month(in_now_day_of_month),
    .in_now_month       (in_now_month),
    .in_now_year        (in_now_year),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_serial_data_out(out_serial_data_out)
  );

  spi_rtc_register_interface_checker #(
    .CLK_REGS  (N_CLOCK_REGS),
    .USER_BYTES(N_USER_BYTES)
  ) miso_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_chip_select     (in_chip_select),
    .in_serial_clock    (in_serial_clock),
    .in_serial_data_in  (in_serial_data_in),
    .in_now_seconds     (in_now_seconds),
    .in_now_minutes     (in_now_minutes),
    .in_now_hours       (in_now_hours),
    .in_now_weekday     (in_now_weekday),
    .in_now_day_of_month(in_now_day_of_month),
    .in_now_month       (in_now_month),
    .in_now_year        (in_now_year),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_serial_data_out(out_serial_data_out),
    .fail_count         (fail_count),
    .pending_count      (pending_count)
  );

  // One pin sample plus the time snapshot that travels with it
  typedef struct {
    logic       cs;
    logic       sck;
    logic       mosi;
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hr;
    logic [2:0] wd;
    logic [4:0] dom;
    logic [3:0] mon;
    logic [6:0] yr;
  } pin_beat_t;

  pin_beat_t  pin_beats [$];
  logic [7:0] frame_data [$];
  pin_beat_t  now_snap;
  bit         hold_en   = 1'b0;
  int         quiet_cycles = 0;

  task automatic set_time(input int s, input int m, input int h, input int w,
                          input int d, input int mo, input int y);
    now_snap.sec = 6'(s);
    now_snap.min = 6'(m);
    now_snap.hr  = 5'(h);
    now_snap.wd  = 3'(w);
    now_snap.dom = 5'(d);
    now_snap.mon = 4'(mo);
    now_snap.yr  = 7'(y);
  endtask

  // Legal time most of the time, full field width otherwise
  task automatic draw_time(input bit wild);
    if (wild)
      set_time($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    else
      set_time($urandom_range(0, 59), $urandom_range(0, 59), $urandom_range(0, 23),
               $urandom_range(0, 6), $urandom_range(1, 31), $urandom_range(0, 11),
               $urandom_range(0, 99));
  endtask

  // Queue a pin beat; in the random part a level is sometimes held an extra beat
  task automatic add_beat(input logic cs, input logic sck, input logic mosi);
    pin_beat_t b;
    b      = now_snap;
    b.cs   = cs;
    b.sck  = sck;
    b.mosi = mosi;
    pin_beats.push_back(b);
    if (hold_en && $urandom_range(0, 9) == 0) begin
      pin_beats.push_back(b);
    end
  endtask

  // Full frame: select, address byte, data bytes, deselect. Data comes from
  // frame_data, random once it runs dry. cut_at aborts at that bit index.
  task automatic spi_frame(input logic idle, input logic [7:0] addr, input int nbytes,
                           input int cut_at);
    logic [7:0] cur;
    int nbits;
    nbits = 8 * (nbytes + 1);
    cur   = addr;
    add_beat(1'b0, idle, 1'($urandom_range(0, 1)));
    add_beat(1'b1, idle, 1'($urandom_range(0, 1)));
    for (int b = 0; b < nbits; b++) begin
      if (b == cut_at) break;
      if (b % 8 == 0 && b != 0) begin
        if (frame_data.size() > 0) cur = frame_data.pop_front();
        else cur = 8'($urandom);
      end
      add_beat(1'b1, ~idle, cur[7 - b % 8]);
      add_beat(1'b1, idle, cur[7 - b % 8]);
    end
    add_beat(1'b0, idle, 1'($urandom_range(0, 1)));
    frame_data.delete();
  endtask

  // User-area offset biased toward the bottom and the wrap point
  function automatic logic [7:0] user_offset();
    case ($urandom_range(0, 3))
      0, 1:    return 8'($urandom_range(0, 7));
      2:       return 8'($urandom_range(N_USER_BYTES - 8, N_USER_BYTES - 1));
      default: return 8'($urandom_range(0, N_USER_BYTES - 1));
    endcase
  endfunction

  // Stimulus and verdict
  initial begin : stimulus
    int         hr_list [5];
    int         pick;
    int         nbytes;
    int         gap;
    bit         gappy;
    logic       idle;
    logic [7:0] addr;
    pin_beat_t  b;

    hr_list = '{0, 12, 13, 23, 31};

    rst_n               <= 1'b0;
    in_valid            <= 1'b0;
    in_chip_select      <= 1'b0;
    in_serial_clock     <= 1'b0;
    in_serial_data_in   <= 1'b1;
    in_now_seconds      <= '0;
    in_now_minutes      <= '0;
    in_now_hours        <= '0;
    in_now_weekday      <= '0;
    in_now_day_of_month <= 5'd1;
    in_now_month        <= '0;
    in_now_year         <= '0;

    // 24-hour mode: zero time, top of range, out-of-range fields
    set_time(0, 0, 0, 0, 1, 0, 0);
    frame_data = {8'h00};
    spi_frame(1'b0, WR_HOURS, 1, NO_CUT);
    spi_frame(1'b0, RD_SECONDS, 7, NO_CUT);
    set_time(59, 59, 23, 6, 31, 11, 99);
    spi_frame(1'b1, RD_SECONDS, 7, NO_CUT);
    set_time(63, 63, 31, 7, 31, 15, 127);
    spi_frame(1'b0, RD_SECONDS, 7, NO_CUT);

    // 12-hour mode: midnight, noon, afternoon, late, out of range
    frame_data = {8'hFF};
    spi_frame(1'b1, WR_HOURS, 1, NO_CUT);
    foreach (hr_list[k]) begin
      set_time(30, 45, hr_list[k], 3, 15, 5, 24);
      spi_frame(1'(k % 2), RD_HOURS, 1, NO_CUT);
    end

    // register seven survives a time load
    frame_data = {8'hA5};
    spi_frame(1'b0, WR_REG7, 1, NO_CUT);
    spi_frame(1'b1, RD_DATE, 3, NO_CUT);

    // write masks of the top registers, write holes, clock-area wraps
    frame_data = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    spi_frame(1'b1, WR_CTRL, 6, NO_CUT);
    spi_frame(1'b0, RD_CTRL, 6, NO_CUT);
    frame_data = {8'hFF, 8'h00};
    spi_frame(1'b0, WR_CLK_TOP, 2, NO_CUT);
    spi_frame(1'b1, RD_CLK_TOP, 2, NO_CUT);

    // user RAM extremes and wraps
    frame_data = {8'hFF, 8'h00, 8'h5A};
    spi_frame(1'b0, WR_USER_TOP, 3, NO_CUT);
    spi_frame(1'b1, RD_USER_TOP, 3, NO_CUT);

    // frames aborted mid-address and mid-data
    spi_frame(1'b0, WR_USER | 8'h03, 1, 5);
    spi_frame(1'b1, RD_USER | 8'h03, 2, 12);

    // random frames, mostly well formed, until the beat budget is used up
    hold_en = 1'b1;
    while (pin_beats.size() < TARGET_BEATS) begin
      if ($urandom_range(0, 2) == 0) draw_time($urandom_range(0, 3) == 0);
      pick   = $urandom_range(0, 99);
      idle   = 1'($urandom_range(0, 1));
      nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
      if (pick < 30) begin
        addr = WR_CLOCK | 8'($urandom_range(0, 31));
        spi_frame(idle, addr, nbytes, NO_CUT);
      end else if (pick < 50) begin
        addr = 8'($urandom_range(0, 31));
        spi_frame(idle, addr, nbytes, NO_CUT);
      end else if (pick < 66) begin
        addr = WR_USER + user_offset();
        spi_frame(idle, addr, nbytes, NO_CUT);
      end else if (pick < 82) begin
        addr = RD_USER + user_offset();
        spi_frame(idle, addr, nbytes, NO_CUT);
      end else if (pick < 92) begin
        addr = 8'($urandom);
        spi_frame(idle, addr, nbytes, $urandom_range(0, 8 * (nbytes + 1) - 1));
      end else begin
        repeat ($urandom_range(4, 24))
          add_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // send every beat; gappy and back-to-back stretches alternate
    gappy = 1'b0;
    for (int n = 0; n < pin_beats.size(); n++) begin
      if (n % 64 == 0) gappy = ($urandom_range(0, 2) != 0);
      gap = gappy ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      b = pin_beats[n];
      in_chip_select      <= b.cs;
      in_serial_clock     <= b.sck;
      in_serial_data_in   <= b.mosi;
      in_now_seconds      <= b.sec;
      in_now_minutes      <= b.min;
      in_now_hours        <= b.hr;
      in_now_weekday      <= b.wd;
      in_now_day_of_month <= b.dom;
      in_now_month        <= b.mon;
      in_now_year         <= b.yr;
      in_valid            <= 1'b1;
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    in_valid <= 1'b0;

    // drain, then a short settle
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side: random hold-offs, two long ones to back the block up
  initial begin : result_sink
    int hold;
    int taken;
    bit gappy;
    taken = 0;
    gappy = 1'b0;
    forever begin
      if (taken % 50 == 0) gappy = ($urandom_range(0, 2) != 0);
      hold = gappy ? $urandom_range(0, 15) : 0;
      if (taken == 400 || taken == 1100) hold = LONG_HOLD;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // Watchdog on cycles with no beat moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
